### src/wats_pkg.sv
package wats_pkg;

  localparam int NUM_SLOTS  = 16;
  localparam int SLOT_W     = 4;
  localparam int NUM_RELAYS = 3;
  localparam int WEEK_DAYS  = 7;

  typedef enum logic [1:0] {
    REQ_TICK       = 2'd0,
    REQ_WRITE_SLOT = 2'd1,
    REQ_SET_ENABLE = 2'd2,
    REQ_SET_MASK   = 2'd3
  } req_code_t;

  // tick time travelling down the row of slot cells
  typedef struct packed {
    logic       active;
    logic [2:0] weekday;
    logic [4:0] hour;
    logic [5:0] minute;
  } scan_tok_t;

  // slot write request, broadcast to every cell
  typedef struct packed {
    req_code_t  req;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] mask;
    logic       enabled;
    logic [1:0] channel;
    logic       level;
  } slot_wr_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] channel;
    logic       level;
  } cell_hit_t;

endpackage

### src/wats_cell.sv
module wats_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_sel,
  input  wats_pkg::slot_wr_t  wr,
  input  logic                clr_marks,
  input  logic                hold,
  input  wats_pkg::scan_tok_t tok_in,
  output wats_pkg::scan_tok_t tok,
  output wats_pkg::cell_hit_t hit
);
  import wats_pkg::*;

  logic       valid;
  logic       executed;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [6:0] mask;
  logic       enabled;
  logic [1:0] channel;
  logic       level;

  logic day_ok;
  logic time_ok;
  logic eligible;

  always_comb begin
    day_ok   = (32'(tok.weekday) < WEEK_DAYS) && mask[tok.weekday];
    time_ok  = (hour < tok.hour) || ((hour == tok.hour) && (minute <= tok.minute));
    eligible = tok.active && valid && enabled && !executed && day_ok && time_ok;
    hit.hit     = eligible;
    hit.channel = channel;
    hit.level   = level;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= 1'b0;
      executed   <= 1'b0;
      tok.active <= 1'b0;
    end else begin
      // pass the tick on unless held by a hit while the output side is full
      if (!hold) begin
        tok <= tok_in;
      end
      if (clr_marks) begin
        executed <= 1'b0;
      end else if (eligible && !hold) begin
        executed <= 1'b1;
      end
      if (wr_sel) begin
        unique case (wr.req)
          REQ_WRITE_SLOT: begin
            valid    <= 1'b1;
            executed <= 1'b0;
            hour     <= wr.hour;
            minute   <= wr.minute;
            mask     <= wr.mask;
            enabled  <= wr.enabled;
            channel  <= wr.channel;
            level    <= wr.level;
          end
          REQ_SET_ENABLE: begin
            if (valid) enabled <= wr.enabled;
          end
          REQ_SET_MASK: begin
            if (valid) mask <= wr.mask;
          end
          REQ_TICK: begin
          end
        endcase
      end
    end
  end

endmodule

### src/weekly_alarm_table_scheduler.sv
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_ready   req_type, slot_index, alarm_*, day_mask, relay_*, now_*
// out      output     out_valid/out_ready fired_slot, fired_channel, fired_level, relay_levels, last
//
// A tick runs one token down the row of sixteen slot cells, one cell a cycle
// unless the scan is held, and the final firing is flushed after the scan ends.
// A firing waits in a pending register so it can be tagged last; the scan stops
// only when a cell hits while both it and the output register are full and
// out_ready is low. Reset (rst, synchronous) invalidates every slot, clears
// executed marks, last day and relays.
module weekly_alarm_table_scheduler (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [3:0] slot_index,
  input  logic [4:0] alarm_hour,
  input  logic [5:0] alarm_minute,
  input  logic [6:0] day_mask,
  input  logic       alarm_enabled,
  input  logic [1:0] relay_channel,
  input  logic       relay_on,
  input  logic [4:0] now_day,
  input  logic [2:0] now_weekday,
  input  logic [4:0] now_hour,
  input  logic [5:0] now_minute,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] fired_slot,
  output logic [1:0] fired_channel,
  output logic       fired_level,
  output logic [2:0] relay_levels,
  output logic       last
);
  import wats_pkg::*;

  scan_tok_t tok_chain [NUM_SLOTS+1];
  cell_hit_t hits      [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] tok_active;
  logic [NUM_SLOTS-1:0] wr_sel;
  slot_wr_t             wr;

  logic                  scanning;
  logic [4:0]            last_day;
  logic [NUM_RELAYS-1:0] relay_state;
  logic [NUM_RELAYS-1:0] relay_next;

  logic                  pend_valid;
  logic [SLOT_W-1:0]     pend_slot;
  logic [1:0]            pend_channel;
  logic                  pend_level;
  logic [NUM_RELAYS-1:0] pend_relays;

  logic              accept;
  logic              tick_go;
  logic              clr_marks;
  logic              hit_any;
  logic [SLOT_W-1:0] hit_slot;
  logic [1:0]        hit_channel;
  logic              hit_level;
  logic              chan_ok;
  logic              out_free;
  logic              hold;
  logic              commit;
  logic              flush;
  logic              scan_end;

  assign accept    = in_valid && in_ready;
  assign tick_go   = accept && (req_code_t'(req_type) == REQ_TICK);
  assign clr_marks = tick_go && (now_day != last_day);
  assign in_ready  = !scanning && !pend_valid;

  assign wr.req     = req_code_t'(req_type);
  assign wr.hour    = alarm_hour;
  assign wr.minute  = alarm_minute;
  assign wr.mask    = day_mask;
  assign wr.enabled = alarm_enabled;
  assign wr.channel = relay_channel;
  assign wr.level   = relay_on;

  assign tok_chain[0].active  = tick_go;
  assign tok_chain[0].weekday = now_weekday;
  assign tok_chain[0].hour    = now_hour;
  assign tok_chain[0].minute  = now_minute;

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    assign wr_sel[g] = accept && (req_code_t'(req_type) != REQ_TICK) &&
                       (slot_index == SLOT_W'(g));
    wats_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_sel    (wr_sel[g]),
      .wr        (wr),
      .clr_marks (clr_marks),
      .hold      (hold),
      .tok_in    (tok_chain[g]),
      .tok       (tok_chain[g+1]),
      .hit       (hits[g])
    );
    assign tok_active[g] = tok_chain[g+1].active;
  end

  // at most one cell holds the token, so OR the hit fields together
  always_comb begin
    hit_any     = 1'b0;
    hit_slot    = '0;
    hit_channel = '0;
    hit_level   = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (hits[i].hit) begin
        hit_any     = 1'b1;
        hit_slot    = hit_slot | SLOT_W'(i);
        hit_channel = hit_channel | hits[i].channel;
        hit_level   = hit_level | hits[i].level;
      end
    end
  end

  always_comb begin
    chan_ok    = (hit_channel != 2'd0) && (32'(hit_channel) <= NUM_RELAYS);
    relay_next = relay_state;
    for (int r = 0; r < NUM_RELAYS; r++) begin
      if (chan_ok && (hit_channel == 2'(r + 1))) relay_next[r] = hit_level;
    end
  end

  assign out_free = !out_valid || out_ready;
  assign hold     = hit_any && pend_valid && !out_free;
  assign commit   = hit_any && !hold;
  assign flush    = !scanning && pend_valid && out_free;
  assign scan_end = tok_active[NUM_SLOTS-1] && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      scanning    <= 1'b0;
      last_day    <= '0;
      relay_state <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (tick_go) begin
        scanning <= 1'b1;
      end else if (scan_end) begin
        scanning <= 1'b0;
      end
      if (clr_marks) last_day <= now_day;

      if (commit) begin
        relay_state  <= relay_next;
        pend_valid   <= 1'b1;
        pend_slot    <= hit_slot;
        pend_channel <= chan_ok ? hit_channel : 2'd0;
        pend_level   <= chan_ok ? hit_level : 1'b0;
        pend_relays  <= relay_next;
      end else if (flush) begin
        pend_valid <= 1'b0;
      end

      // move the pending firing out: not last if another one replaces it
      if ((commit && pend_valid) || flush) begin
        out_valid     <= 1'b1;
        fired_slot    <= pend_slot;
        fired_channel <= pend_channel;
        fired_level   <= pend_level;
        relay_levels  <= 3'(pend_relays);
        last          <= flush;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_tok_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_active))
    else $error("more than one scan token in the cell row");

  a_tick_start: assert property (@(posedge clk) disable iff (rst) tick_go |=> tok_active[0])
    else $error("accepted tick did not enter the first cell");

  a_hold_freeze: assert property (@(posedge clk) disable iff (rst)
      hold |=> $stable(tok_active))
    else $error("scan token moved while held");

  a_no_ready_scan: assert property (@(posedge clk) disable iff (rst)
      (tok_active != '0) |-> !in_ready)
    else $error("input ready while a scan is running");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import wats_pkg::*;

  typedef struct packed {
    req_code_t  req;
    logic [3:0] slot;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] mask;
    logic       enabled;
    logic [1:0] channel;
    logic       level;
    logic [4:0] day;
    logic [2:0] weekday;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
  } alarm_req_t;

  typedef struct packed {
    logic       valid;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] mask;
    logic       enabled;
    logic [1:0] channel;
    logic       level;
  } alarm_slot_t;

  typedef struct packed {
    logic [3:0] slot;
    logic [1:0] channel;
    logic       level;
    logic [2:0] levels;
    logic       is_last;
  } firing_t;

  class alarm_scoreboard;
    alarm_slot_t slots [NUM_SLOTS];
    bit          executed [NUM_SLOTS];
    logic [4:0]  seen_day;
    logic [2:0]  relays;
    firing_t     due[$];
    int          errors, ticks, writes, ignored, checked, max_burst;

    function new();
      foreach (slots[i]) begin
        slots[i] = '0;
        executed[i] = 1'b0;
      end
      seen_day = '0;
      relays = '0;
      errors = 0;
      ticks = 0;
      writes = 0;
      ignored = 0;
      checked = 0;
      max_burst = 0;
    endfunction

    function string show(firing_t f);
      return $sformatf("slot %0d ch %0d level %0d relays %b last %0d",
                       f.slot, f.channel, f.level, f.levels, f.is_last);
    endfunction

    function void complain(string msg);
      errors++;
      if (errors <= 10) $display("%t: %s", $realtime, msg);
    endfunction

    // Returns 0 for a request that leaves the table untouched.
    function bit note_request(alarm_req_t r);
      firing_t f, prev;
      bit      have_prev;
      int      burst;
      if (r.req != REQ_TICK) begin
        if (r.req == REQ_WRITE_SLOT) begin
          slots[r.slot].valid   = 1'b1;
          slots[r.slot].hour    = r.hour;
          slots[r.slot].minute  = r.minute;
          slots[r.slot].mask    = r.mask;
          slots[r.slot].enabled = r.enabled;
          slots[r.slot].channel = r.channel;
          slots[r.slot].level   = r.level;
          executed[r.slot] = 1'b0;
          writes++;
          return 1'b1;
        end
        if (!slots[r.slot].valid) begin
          ignored++;
          return 1'b0;
        end
        if (r.req == REQ_SET_ENABLE) slots[r.slot].enabled = r.enabled;
        else slots[r.slot].mask = r.mask;
        writes++;
        return 1'b1;
      end

      ticks++;
      if (r.day != seen_day) begin
        foreach (executed[i]) executed[i] = 1'b0;
        seen_day = r.day;
      end
      have_prev = 1'b0;
      burst = 0;
      prev = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!slots[i].valid || !slots[i].enabled || executed[i]) continue;
        if (r.weekday >= WEEK_DAYS || ((slots[i].mask >> r.weekday) & 7'd1) == 7'd0) continue;
        if (slots[i].hour > r.now_hour ||
            (slots[i].hour == r.now_hour && slots[i].minute > r.now_minute)) continue;
        executed[i] = 1'b1;
        f = '0;
        f.slot = SLOT_W'(i);
        if (slots[i].channel >= 1 && slots[i].channel <= NUM_RELAYS) begin
          f.channel = slots[i].channel;
          f.level = slots[i].level;
          relays[slots[i].channel - 1] = slots[i].level;
        end
        f.levels = relays;
        // hold each firing back one step so the final one can be tagged last
        if (have_prev) due = {due, prev};
        prev = f;
        have_prev = 1'b1;
        burst++;
      end
      if (have_prev) begin
        prev.is_last = 1'b1;
        due = {due, prev};
      end
      if (burst > max_burst) max_burst = burst;
      return 1'b1;
    endfunction

    function void check_firing(firing_t got);
      firing_t want;
      if (due.size() == 0) begin
        complain({"firing with nothing pending: ", show(got)});
        return;
      end
      want = due.pop_front();
      checked++;
      if (got !== want) complain({"firing mismatch: want ", show(want), ", got ", show(got)});
    endfunction

    function void flag_leftovers();
      while (due.size() != 0) complain({"firing never seen: ", show(due.pop_front())});
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] req_type;
  logic [3:0] slot_index;
  logic [4:0] alarm_hour;
  logic [5:0] alarm_minute;
  logic [6:0] day_mask;
  logic       alarm_enabled;
  logic [1:0] relay_channel;
  logic       relay_on;
  logic [4:0] now_day;
  logic [2:0] now_weekday;
  logic [4:0] now_hour;
  logic [5:0] now_minute;
  logic       out_valid;
  logic       out_ready;
  logic [3:0] fired_slot;
  logic [1:0] fired_channel;
  logic       fired_level;
  logic [2:0] relay_levels;
  logic       last;

  alarm_scoreboard sb = new();
  bit gaps_in = 1'b1;
  bit gaps_out = 1'b1;
  int n_effective = 0;

  weekly_alarm_table_scheduler i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .slot_index    (slot_index),
    .alarm_hour    (alarm_hour),
    .alarm_minute  (alarm_minute),
    .day_mask      (day_mask),
    .alarm_enabled (alarm_enabled),
    .relay_channel (relay_channel),
    .relay_on      (relay_on),
    .now_day       (now_day),
    .now_weekday   (now_weekday),
    .now_hour      (now_hour),
    .now_minute    (now_minute),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .fired_slot    (fired_slot),
    .fired_channel (fired_channel),
    .fired_level   (fired_level),
    .relay_levels  (relay_levels),
    .last          (last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

  // Unused fields carry random bits so every input bit toggles.
  function automatic alarm_req_t any_request();
    alarm_req_t r;
    r.req        = req_code_t'($urandom_range(0, 3));
    r.slot       = 4'($urandom);
    r.hour       = 5'($urandom);
    r.minute     = 6'($urandom);
    r.mask       = 7'($urandom);
    r.enabled    = 1'($urandom);
    r.channel    = 2'($urandom);
    r.level      = 1'($urandom);
    r.day        = 5'($urandom);
    r.weekday    = 3'($urandom);
    r.now_hour   = 5'($urandom);
    r.now_minute = 6'($urandom);
    return r;
  endfunction

  function automatic alarm_req_t slot_write(logic [3:0] idx, logic [4:0] h, logic [5:0] m,
                                            logic [6:0] mask, logic en, logic [1:0] ch,
                                            logic lv);
    alarm_req_t r;
    r = any_request();
    r.req = REQ_WRITE_SLOT;
    r.slot = idx;
    r.hour = h;
    r.minute = m;
    r.mask = mask;
    r.enabled = en;
    r.channel = ch;
    r.level = lv;
    return r;
  endfunction

  function automatic alarm_req_t enable_write(logic [3:0] idx, logic en);
    alarm_req_t r;
    r = any_request();
    r.req = REQ_SET_ENABLE;
    r.slot = idx;
    r.enabled = en;
    return r;
  endfunction

  function automatic alarm_req_t mask_write(logic [3:0] idx, logic [6:0] mask);
    alarm_req_t r;
    r = any_request();
    r.req = REQ_SET_MASK;
    r.slot = idx;
    r.mask = mask;
    return r;
  endfunction

  function automatic alarm_req_t tick_at(logic [4:0] day, logic [2:0] wd, logic [4:0] h,
                                         logic [5:0] m);
    alarm_req_t r;
    r = any_request();
    r.req = REQ_TICK;
    r.day = day;
    r.weekday = wd;
    r.now_hour = h;
    r.now_minute = m;
    return r;
  endfunction

  // Entered and left on a rising edge; the request is taken at the exit edge.
  task automatic send_request(alarm_req_t r);
    if (gaps_in && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_type      <= r.req;
    slot_index    <= r.slot;
    alarm_hour    <= r.hour;
    alarm_minute  <= r.minute;
    day_mask      <= r.mask;
    alarm_enabled <= r.enabled;
    relay_channel <= r.channel;
    relay_on      <= r.level;
    now_day       <= r.day;
    now_weekday   <= r.weekday;
    now_hour      <= r.now_hour;
    now_minute    <= r.now_minute;
    in_valid      <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (sb.note_request(r)) n_effective++;
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (gaps_out && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_firing({fired_slot, fired_channel, fired_level, relay_levels, last});
  end

  initial begin
    int         cur_min;
    logic [4:0] cur_day;
    logic [2:0] cur_wday;
    int         kind;
    int         pick;
    int         waited;

    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= '0;
    slot_index <= '0;
    alarm_hour <= '0;
    alarm_minute <= '0;
    day_mask <= '0;
    alarm_enabled <= 1'b0;
    relay_channel <= '0;
    relay_on <= 1'b0;
    now_day <= '0;
    now_weekday <= '0;
    now_hour <= '0;
    now_minute <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // edits to empty slots, then a day-zero tick before any day was seen
    send_request(enable_write(4'd5, 1'b1));
    send_request(mask_write(4'd9, 7'h7f));
    send_request(tick_at(5'd0, 3'd6, 5'd31, 6'd63));
    send_request(slot_write(4'd0, 5'd0, 6'd0, 7'h7f, 1'b1, 2'd1, 1'b1));
    send_request(slot_write(4'd15, 5'd23, 6'd59, 7'h40, 1'b1, 2'd3, 1'b1));
    send_request(slot_write(4'd7, 5'd12, 6'd30, 7'h01, 1'b1, 2'd2, 1'b1));
    send_request(slot_write(4'd3, 5'd0, 6'd0, 7'h7f, 1'b0, 2'd0, 1'b1));
    send_request(tick_at(5'd0, 3'd6, 5'd23, 6'd59));
    send_request(tick_at(5'd0, 3'd6, 5'd23, 6'd59));
    // new day: one minute early for slot 7, then on time
    send_request(tick_at(5'd1, 3'd0, 5'd12, 6'd29));
    send_request(tick_at(5'd1, 3'd0, 5'd12, 6'd30));
    send_request(enable_write(4'd3, 1'b1));
    send_request(mask_write(4'd0, 7'h00));
    send_request(enable_write(4'd15, 1'b0));
    send_request(tick_at(5'd1, 3'd0, 5'd31, 6'd63));
    // weekday past Saturday matches nothing
    send_request(tick_at(5'd2, 3'd7, 5'd31, 6'd63));
    send_request(slot_write(4'd7, 5'd12, 6'd30, 7'h7f, 1'b1, 2'd2, 1'b0));
    send_request(slot_write(4'd15, 5'd31, 6'd63, 7'h7f, 1'b1, 2'd3, 1'b0));
    send_request(slot_write(4'd9, 5'd31, 6'd0, 7'h08, 1'b1, 2'd1, 1'b0));
    send_request(tick_at(5'd31, 3'd3, 5'd31, 6'd63));
    send_request(tick_at(5'd30, 3'd3, 5'd0, 6'd0));

    cur_min = 0;
    cur_day = 5'd1;
    cur_wday = 3'd0;
    while (n_effective < 280) begin
      // no idling near the end of the run
      gaps_in  = (n_effective < 240) && ($urandom_range(0, 4) != 0);
      gaps_out = (n_effective < 240) && ($urandom_range(0, 4) != 0);
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        // arm every slot at midnight so one tick fires the whole table
        for (int s = 0; s < NUM_SLOTS; s++)
          send_request(slot_write(4'(s), 5'd0, 6'd0, 7'h7f, 1'b1, 2'($urandom),
                                  1'($urandom)));
        send_request(tick_at(cur_day, cur_wday, 5'(cur_min / 60), 6'(cur_min % 60)));
      end else if (kind <= 2) begin
        repeat ($urandom_range(1, 4)) send_request(any_request());
      end else begin
        repeat ($urandom_range(1, 5)) begin
          pick = $urandom_range(0, 9);
          if (pick < 7)
            send_request(slot_write(4'($urandom), 5'($urandom_range(0, 23)),
                                    6'($urandom_range(0, 59)),
                                    ($urandom_range(0, 2) == 0) ? 7'h7f : 7'($urandom),
                                    $urandom_range(0, 5) != 0, 2'($urandom), 1'($urandom)));
          else if (pick < 8)
            send_request(enable_write(4'($urandom), 1'($urandom)));
          else
            send_request(mask_write(4'($urandom), 7'($urandom)));
        end
        repeat ($urandom_range(1, 3)) begin
          cur_min += $urandom_range(0, 240);
          if (cur_min >= 1440 || $urandom_range(0, 9) == 0) begin
            cur_min = $urandom_range(0, 120);
            cur_day = (cur_day % 5'd31) + 5'd1;
            cur_wday = (cur_wday == 3'd6) ? 3'd0 : cur_wday + 3'd1;
          end
          send_request(tick_at(cur_day, cur_wday, 5'(cur_min / 60), 6'(cur_min % 60)));
        end
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (sb.due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    sb.flag_leftovers();

    $display("%0d requests taken: %0d ticks, %0d table edits, %0d edits to empty slots",
             n_effective + sb.ignored, sb.ticks, sb.writes, sb.ignored);
    $display("%0d firings checked, up to %0d in one tick, %0d mismatches",
             sb.checked, sb.max_burst, sb.errors);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/wats_pkg.sv
src/wats_cell.sv
src/weekly_alarm_table_scheduler.sv
verif/testbench.sv
